@@ src/i2cm_pkg.sv @@
package i2cm_pkg;

  // Command codes carried in the cmd field.
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_RDACK = 3'd4;
  localparam logic [2:0] OP_RDNAK = 3'd5;

  // Configuration register indexes.
  localparam logic [7:0] CFG_ACK_TIMEOUT = 8'd0;
  localparam logic [7:0] CFG_UNIT_TICKS  = 8'd1;

  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;
  localparam logic [7:0] UNIT_TICKS_RST  = 8'd1;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_ST_A    = 5'd1,
    PH_ST_B    = 5'd2,
    PH_SP_A    = 5'd3,
    PH_SP_B    = 5'd4,
    PH_WR_SET  = 5'd5,
    PH_WR_HIGH = 5'd6,
    PH_WR_LOW  = 5'd7,
    PH_AK_REL  = 5'd8,
    PH_AK_HIGH = 5'd9,
    PH_AK_POLL = 5'd10,
    PH_RD_LOW  = 5'd11,
    PH_RD_HIGH = 5'd12,
    PH_KA_LOW  = 5'd13,
    PH_KA_HIGH = 5'd14
  } phase_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] tx_byte;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_driven;
    logic       busy_res;
    logic       done_res;
    logic       ack_failed;
    logic [7:0] rx_byte;
  } result_t;

  typedef struct packed {
    logic [7:0] ack_timeout;
    logic [7:0] unit_ticks;
  } cfg_t;

endpackage

@@ src/i2cm_intf.sv @@
interface i2cm_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] tx_byte;
  logic       sda_in;

  modport source (output valid, output cmd, output tx_byte, output sda_in, input ready);
  modport sink   (input valid, input cmd, input tx_byte, input sda_in, output ready);
endinterface

interface i2cm_rsp_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_driven;
  logic       busy_res;
  logic       done_res;
  logic       ack_failed;
  logic [7:0] rx_byte;

  modport source (output valid, output scl_level, output sda_level, output sda_driven,
                  output busy_res, output done_res, output ack_failed, output rx_byte,
                  input ready);
  modport sink   (input valid, input scl_level, input sda_level, input sda_driven,
                  input busy_res, input done_res, input ack_failed, input rx_byte,
                  output ready);
endinterface

interface i2cm_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/i2cm_seq.sv @@
module i2cm_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  i2cm_pkg::item_t   item,
  input  i2cm_pkg::cfg_t    cfg,
  output i2cm_pkg::result_t result
);

  i2cm_pkg::phase_t phase, phase_next;
  logic [2:0] active_op, active_op_next;
  logic [3:0] bit_count, bit_count_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic [9:0] hold_count, hold_count_next;
  logic [7:0] ack_wait, ack_wait_next;
  logic       scl, scl_next;
  logic       sda, sda_next;
  logic       drv, drv_next;
  logic       failure, failure_next;
  logic [7:0] rx_reg, rx_reg_next;
  logic       done;

  logic [7:0] unit_eff;
  logic [9:0] hold_1u, hold_2u, hold_4u, hold_dec;
  logic [3:0] bit_inc;
  logic [7:0] shift_in;
  logic       cmd_ok;

  assign unit_eff = (cfg.unit_ticks == 8'd0) ? 8'd1 : cfg.unit_ticks;
  assign hold_1u  = {2'b00, unit_eff};
  assign hold_2u  = {1'b0, unit_eff, 1'b0};
  assign hold_4u  = {unit_eff, 2'b00};
  assign hold_dec = (hold_count != 10'd0) ? hold_count - 10'd1 : hold_count;
  assign bit_inc  = bit_count + 4'd1;
  assign shift_in = {shift_reg[6:0], item.sda_in};
  assign cmd_ok   = (item.cmd >= i2cm_pkg::OP_START) && (item.cmd <= i2cm_pkg::OP_RDNAK);

  // Next phase.
  always_comb begin
    phase_next = phase;
    case (phase)
      i2cm_pkg::PH_IDLE: begin
        if (cmd_ok) begin
          case (item.cmd)
            i2cm_pkg::OP_START: phase_next = i2cm_pkg::PH_ST_A;
            i2cm_pkg::OP_STOP:  phase_next = i2cm_pkg::PH_SP_A;
            i2cm_pkg::OP_WRITE: phase_next = i2cm_pkg::PH_WR_SET;
            default:            phase_next = i2cm_pkg::PH_RD_LOW;
          endcase
        end
      end
      i2cm_pkg::PH_AK_POLL: begin
        if (!item.sda_in) phase_next = i2cm_pkg::PH_IDLE;
        else if (ack_wait >= cfg.ack_timeout) phase_next = i2cm_pkg::PH_SP_A;
      end
      default: begin
        if (hold_dec == 10'd0) begin
          case (phase)
            i2cm_pkg::PH_ST_A:    phase_next = i2cm_pkg::PH_ST_B;
            i2cm_pkg::PH_SP_A:    phase_next = i2cm_pkg::PH_SP_B;
            i2cm_pkg::PH_WR_SET:  phase_next = i2cm_pkg::PH_WR_HIGH;
            i2cm_pkg::PH_WR_HIGH: phase_next = i2cm_pkg::PH_WR_LOW;
            i2cm_pkg::PH_WR_LOW:
              phase_next = (bit_inc >= 4'd8) ? i2cm_pkg::PH_AK_REL : i2cm_pkg::PH_WR_SET;
            i2cm_pkg::PH_AK_REL:  phase_next = i2cm_pkg::PH_AK_HIGH;
            i2cm_pkg::PH_AK_HIGH: phase_next = i2cm_pkg::PH_AK_POLL;
            i2cm_pkg::PH_RD_LOW:  phase_next = i2cm_pkg::PH_RD_HIGH;
            i2cm_pkg::PH_RD_HIGH:
              phase_next = (bit_inc >= 4'd8) ? i2cm_pkg::PH_KA_LOW : i2cm_pkg::PH_RD_LOW;
            i2cm_pkg::PH_KA_LOW:  phase_next = i2cm_pkg::PH_KA_HIGH;
            default:              phase_next = i2cm_pkg::PH_IDLE;
          endcase
        end
      end
    endcase
  end

  // Datapath, line levels and done pulse.
  always_comb begin
    active_op_next  = active_op;
    bit_count_next  = bit_count;
    shift_reg_next  = shift_reg;
    hold_count_next = hold_count;
    ack_wait_next   = ack_wait;
    scl_next        = scl;
    sda_next        = sda;
    drv_next        = drv;
    failure_next    = failure;
    rx_reg_next     = rx_reg;
    done            = 1'b0;
    case (phase)
      i2cm_pkg::PH_IDLE: begin
        if (cmd_ok) begin
          active_op_next = item.cmd;
          failure_next   = 1'b0;
          bit_count_next = 4'd0;
          ack_wait_next  = 8'd0;
          case (item.cmd)
            i2cm_pkg::OP_START: begin
              {scl_next, sda_next, drv_next} = 3'b111;
              hold_count_next = hold_4u;
            end
            i2cm_pkg::OP_STOP: begin
              {scl_next, sda_next, drv_next} = 3'b001;
              hold_count_next = hold_4u;
            end
            i2cm_pkg::OP_WRITE: begin
              {scl_next, sda_next, drv_next} = {1'b0, item.tx_byte[7], 1'b1};
              shift_reg_next  = {item.tx_byte[6:0], 1'b0};
              hold_count_next = hold_1u;
            end
            default: begin
              shift_reg_next = 8'd0;
              {scl_next, sda_next, drv_next} = 3'b010;
              hold_count_next = hold_1u;
            end
          endcase
        end
      end
      i2cm_pkg::PH_AK_POLL: begin
        if (!item.sda_in) begin
          scl_next = 1'b0;
          done     = 1'b1;
        end else if (ack_wait >= cfg.ack_timeout) begin
          {scl_next, sda_next, drv_next} = 3'b001;
          hold_count_next = hold_4u;
        end else begin
          ack_wait_next = ack_wait + 8'd1;
        end
      end
      default: begin
        hold_count_next = hold_dec;
        if (hold_dec == 10'd0) begin
          case (phase)
            i2cm_pkg::PH_ST_A: begin
              sda_next        = 1'b0;
              hold_count_next = hold_4u;
            end
            i2cm_pkg::PH_ST_B: begin
              scl_next = 1'b0;
              done     = 1'b1;
            end
            i2cm_pkg::PH_SP_A: begin
              {scl_next, sda_next, drv_next} = 3'b111;
              hold_count_next = hold_4u;
            end
            i2cm_pkg::PH_SP_B: begin
              if (active_op == i2cm_pkg::OP_WRITE) failure_next = 1'b1;
              done = 1'b1;
            end
            i2cm_pkg::PH_WR_SET, i2cm_pkg::PH_AK_REL, i2cm_pkg::PH_RD_LOW: begin
              scl_next        = 1'b1;
              hold_count_next = hold_1u;
            end
            i2cm_pkg::PH_WR_HIGH: begin
              scl_next        = 1'b0;
              hold_count_next = hold_1u;
            end
            i2cm_pkg::PH_WR_LOW: begin
              bit_count_next  = bit_inc;
              hold_count_next = hold_1u;
              if (bit_inc >= 4'd8) begin
                {scl_next, sda_next, drv_next} = 3'b010;
              end else begin
                {scl_next, sda_next, drv_next} = {1'b0, shift_reg[7], 1'b1};
                shift_reg_next = {shift_reg[6:0], 1'b0};
              end
            end
            i2cm_pkg::PH_AK_HIGH: begin
              ack_wait_next   = 8'd0;
              hold_count_next = 10'd0;
            end
            i2cm_pkg::PH_RD_HIGH: begin
              shift_reg_next  = shift_in;
              bit_count_next  = bit_inc;
              hold_count_next = hold_1u;
              if (bit_inc >= 4'd8) begin
                rx_reg_next = shift_in;
                {scl_next, sda_next, drv_next} =
                  {1'b0, active_op != i2cm_pkg::OP_RDACK, 1'b1};
              end else begin
                scl_next = 1'b0;
              end
            end
            i2cm_pkg::PH_KA_LOW: begin
              scl_next        = 1'b1;
              hold_count_next = (active_op == i2cm_pkg::OP_RDACK) ? hold_2u : hold_1u;
            end
            i2cm_pkg::PH_KA_HIGH: begin
              scl_next = 1'b0;
              done     = 1'b1;
            end
            default: done = 1'b1;
          endcase
        end
      end
    endcase
  end

  assign result.scl_level  = scl_next;
  assign result.sda_level  = sda_next;
  assign result.sda_driven = drv_next;
  assign result.busy_res   = (phase_next != i2cm_pkg::PH_IDLE);
  assign result.done_res   = done;
  assign result.ack_failed = failure_next;
  assign result.rx_byte    = rx_reg_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= i2cm_pkg::PH_IDLE;
      active_op  <= i2cm_pkg::OP_NONE;
      bit_count  <= 4'd0;
      shift_reg  <= 8'd0;
      hold_count <= 10'd0;
      ack_wait   <= 8'd0;
      scl        <= 1'b1;
      sda        <= 1'b1;
      drv        <= 1'b1;
      failure    <= 1'b0;
      rx_reg     <= 8'd0;
    end else if (en) begin
      phase      <= phase_next;
      active_op  <= active_op_next;
      bit_count  <= bit_count_next;
      shift_reg  <= shift_reg_next;
      hold_count <= hold_count_next;
      ack_wait   <= ack_wait_next;
      scl        <= scl_next;
      sda        <= sda_next;
      drv        <= drv_next;
      failure    <= failure_next;
      rx_reg     <= rx_reg_next;
    end
  end

endmodule

@@ src/i2c_master_bit_engine_top.sv @@
// I2C master bit engine.
//
// req carries one bus timing tick per word: a command (0 tick only, 1 start,
// 2 stop, 3 write byte, 4 read with ACK, 5 read with NACK), the byte to send
// and the sampled SDA level. Commands are taken only while the engine is idle;
// software sequences the primitives and watches busy_res and done_res.
// rsp returns one word per tick: SCL/SDA drive levels, SDA drive enable,
// busy, a one-tick done pulse, the ACK failure flag and the last read byte.
// cfg writes ack_timeout (index 0) and unit_ticks (index 1); it is always
// ready, and writes to other indexes are dropped.
//
// The result of a tick is registered and appears on rsp in the cycle after the
// tick is taken. Throughput: one tick per cycle while rsp is not stalled, set by
// the sequencer update feeding the result register.
// Reset: lines idle high with SDA driven, engine idle, ack_timeout 250,
// unit_ticks 1. When rsp stalls, the waiting result holds and req drops ready
// until the result is taken, so no tick is lost.
module i2c_master_bit_engine_top (
  input logic clk,
  input logic rst,
  i2cm_req_if.sink   req,
  i2cm_rsp_if.source rsp,
  i2cm_cfg_if.sink   cfg
);

  i2cm_pkg::cfg_t    cfg_regs;
  i2cm_pkg::item_t   item;
  i2cm_pkg::result_t step_res;
  i2cm_pkg::result_t rsp_word;
  logic              rsp_valid;
  logic              req_take;

  // Take a tick whenever the result slot is free or being emptied this cycle.
  assign req.ready = !rsp_valid || rsp.ready;
  assign req_take  = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  assign item.cmd     = req.cmd;
  assign item.tx_byte = req.tx_byte;
  assign item.sda_in  = req.sda_in;

  // Configuration registers; load each write at its accepting edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.ack_timeout <= i2cm_pkg::ACK_TIMEOUT_RST;
      cfg_regs.unit_ticks  <= i2cm_pkg::UNIT_TICKS_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        i2cm_pkg::CFG_ACK_TIMEOUT: cfg_regs.ack_timeout <= cfg.data;
        i2cm_pkg::CFG_UNIT_TICKS:  cfg_regs.unit_ticks  <= cfg.data;
        default: ;
      endcase
    end
  end

  // Advance the sequencer by one tick per accepted word.
  i2cm_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .en     (req_take),
    .item   (item),
    .cfg    (cfg_regs),
    .result (step_res)
  );

  // Result register: load on each accepted tick, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (req_take) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      rsp_word <= step_res;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.scl_level  = rsp_word.scl_level;
  assign rsp.sda_level  = rsp_word.sda_level;
  assign rsp.sda_driven = rsp_word.sda_driven;
  assign rsp.busy_res   = rsp_word.busy_res;
  assign rsp.done_res   = rsp_word.done_res;
  assign rsp.ack_failed = rsp_word.ack_failed;
  assign rsp.rx_byte    = rsp_word.rx_byte;

endmodule
